@@ rtl/core/prs_pkg.sv @@
// Package: shared widths, codes and types of the power rail sequencer.
`default_nettype none

package prs_pkg;

    // Field widths
    localparam int SUPPLY_W       = 16;
    localparam int STATE_W        = 4;
    localparam int KIND_W         = 3;
    localparam int GROUP_W        = 3;
    localparam int EVENT_W        = 3;
    localparam int CODE_W         = 3;
    localparam int STATUS_W       = SUPPLY_W * CODE_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int SUPPLY_COUNT_D = 16;

    // Sequencer states
    localparam logic [STATE_W-1:0] ST_FAIL  = 4'd0;
    localparam logic [STATE_W-1:0] ST_INIT  = 4'd1;
    localparam logic [STATE_W-1:0] ST_DOWN  = 4'd2;
    localparam logic [STATE_W-1:0] ST_OFF   = 4'd3;
    localparam logic [STATE_W-1:0] ST_CLOCK = 4'd4;
    localparam logic [STATE_W-1:0] ST_KU    = 4'd5;
    localparam logic [STATE_W-1:0] ST_ZU    = 4'd6;
    localparam logic [STATE_W-1:0] ST_VU    = 4'd7;
    localparam logic [STATE_W-1:0] ST_FF    = 4'd8;
    localparam logic [STATE_W-1:0] ST_ON    = 4'd9;

    // Commands
    localparam logic [KIND_W-1:0] CMD_NONE      = 3'd0;
    localparam logic [KIND_W-1:0] CMD_POWER_OFF = 3'd1;
    localparam logic [KIND_W-1:0] CMD_TEMP_SET  = 3'd2;
    localparam logic [KIND_W-1:0] CMD_TEMP_CLR  = 3'd3;
    localparam logic [KIND_W-1:0] CMD_POWER_ON  = 3'd4;
    localparam logic [KIND_W-1:0] CMD_ALARM_CLR = 3'd5;

    // Priority groups
    localparam logic [GROUP_W-1:0] GRP_NONE = 3'd0;
    localparam logic [GROUP_W-1:0] GRP_1    = 3'd1;
    localparam logic [GROUP_W-1:0] GRP_2    = 3'd2;
    localparam logic [GROUP_W-1:0] GRP_3    = 3'd3;
    localparam logic [GROUP_W-1:0] GRP_4    = 3'd4;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SUPPLY    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_TEMP_OFF  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_POWER_OFF = 3'd3;
    localparam logic [EVENT_W-1:0] EV_POWER_ON  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_CLEARED   = 3'd5;

    // Per-supply status codes
    localparam logic [CODE_W-1:0] SS_UNCHANGED = 3'd0;
    localparam logic [CODE_W-1:0] SS_ON        = 3'd1;
    localparam logic [CODE_W-1:0] SS_DISABLED  = 3'd2;
    localparam logic [CODE_W-1:0] SS_OFF       = 3'd3;
    localparam logic [CODE_W-1:0] SS_FAILED    = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GENERAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KU      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZU      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VU      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FF      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALT     = 3'd7;

    typedef struct packed {
        logic [SUPPLY_W-1:0] general_mask;
        logic [SUPPLY_W-1:0] clock_mask;
        logic [SUPPLY_W-1:0] ku_mask;
        logic [SUPPLY_W-1:0] zu_mask;
        logic [SUPPLY_W-1:0] vu_mask;
        logic [SUPPLY_W-1:0] ff_mask;
        logic                ignore_fail;
        logic                alternate_path;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                blade_enable;
        logic [SUPPLY_W-1:0] good_bits;
        logic [SUPPLY_W-1:0] good_bits_after;
    } t_tick;

    typedef struct packed {
        logic [STATE_W-1:0]  old_state;
        logic [STATE_W-1:0]  new_state;
        logic                disable_all;
        logic [GROUP_W-1:0]  enable_group;
        logic                blade_ok;
        logic [EVENT_W-1:0]  event_code;
        logic [SUPPLY_W-1:0] failed_out;
        logic                supply_alarm_out;
        logic                external_alarm_out;
    } t_seq_out;

    typedef struct packed {
        logic [STATE_W-1:0]  new_state;
        logic                disable_all;
        logic [GROUP_W-1:0]  enable_group;
        logic                blade_ok;
        logic [EVENT_W-1:0]  event_code;
        logic [SUPPLY_W-1:0] failed_out;
        logic                supply_alarm_out;
        logic                external_alarm_out;
        logic [STATUS_W-1:0] status_vector;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/prs_tick_if.sv @@
// Interface: input channel carrying one polling tick.
`default_nettype none

interface prs_tick_if;
    logic                          valid;
    logic                          ready;
    logic [prs_pkg::KIND_W-1:0]    kind;
    logic                          blade_enable;
    logic [prs_pkg::SUPPLY_W-1:0]  good_bits;
    logic [prs_pkg::SUPPLY_W-1:0]  good_bits_after;

    modport source (output valid, kind, blade_enable, good_bits, good_bits_after,
                    input ready);
    modport sink   (input valid, kind, blade_enable, good_bits, good_bits_after,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/prs_result_if.sv @@
// Interface: output channel carrying one sequencer result.
`default_nettype none

interface prs_result_if;
    logic                          valid;
    logic                          ready;
    logic [prs_pkg::STATE_W-1:0]   new_state;
    logic                          disable_all;
    logic [prs_pkg::GROUP_W-1:0]   enable_group;
    logic                          blade_ok;
    logic [prs_pkg::EVENT_W-1:0]   event_code;
    logic [prs_pkg::SUPPLY_W-1:0]  failed_out;
    logic                          supply_alarm_out;
    logic                          external_alarm_out;
    logic [prs_pkg::STATUS_W-1:0]  status_vector;

    modport source (output valid, new_state, disable_all, enable_group, blade_ok,
                    event_code, failed_out, supply_alarm_out, external_alarm_out,
                    status_vector, input ready);
    modport sink   (input valid, new_state, disable_all, enable_group, blade_ok,
                    event_code, failed_out, supply_alarm_out, external_alarm_out,
                    status_vector, output ready);
endinterface

`default_nettype wire

@@ rtl/core/prs_cfg_regs.sv @@
// Configuration register file of the power rail sequencer.
`default_nettype none

module prs_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [prs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [prs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output prs_pkg::t_cfg                         o_cfg
);

    prs_pkg::t_cfg r_cfg;

    // register writes, decoded by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.general_mask   <= '1;
            r_cfg.clock_mask     <= '0;
            r_cfg.ku_mask        <= '0;
            r_cfg.zu_mask        <= '0;
            r_cfg.vu_mask        <= '0;
            r_cfg.ff_mask        <= '0;
            r_cfg.ignore_fail    <= 1'b1;
            r_cfg.alternate_path <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                prs_pkg::REG_GENERAL: r_cfg.general_mask   <= i_cfg_data;
                prs_pkg::REG_CLOCK:   r_cfg.clock_mask     <= i_cfg_data;
                prs_pkg::REG_KU:      r_cfg.ku_mask        <= i_cfg_data;
                prs_pkg::REG_ZU:      r_cfg.zu_mask        <= i_cfg_data;
                prs_pkg::REG_VU:      r_cfg.vu_mask        <= i_cfg_data;
                prs_pkg::REG_FF:      r_cfg.ff_mask        <= i_cfg_data;
                prs_pkg::REG_IGNORE:  r_cfg.ignore_fail    <= i_cfg_data[0];
                prs_pkg::REG_ALT:     r_cfg.alternate_path <= i_cfg_data[0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/core/prs_seq_core.sv @@
// Sequencer state, request/alarm flags and the per-tick state decision.
`default_nettype none

module prs_seq_core #(
    parameter int SUPPLY_COUNT = prs_pkg::SUPPLY_COUNT_D
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  prs_pkg::t_cfg       i_cfg,
    input  prs_pkg::t_tick      i_tick,
    output prs_pkg::t_seq_out   o_seq
);

    localparam logic [prs_pkg::SUPPLY_W-1:0] USED_RAILS =
        (SUPPLY_COUNT >= prs_pkg::SUPPLY_W) ? '1 :
        prs_pkg::SUPPLY_W'((32'd1 << SUPPLY_COUNT) - 32'd1);

    logic [prs_pkg::STATE_W-1:0]  r_state, n_state;
    logic                         r_down_req, n_down_req;
    logic                         r_temp_alarm, n_temp_alarm;
    logic                         r_rail_alarm, n_rail_alarm;
    logic [prs_pkg::SUPPLY_W-1:0] r_failed, n_failed;

    logic [prs_pkg::SUPPLY_W-1:0] good;
    logic                         cmd_down, cmd_temp, cmd_rail;
    logic [prs_pkg::SUPPLY_W-1:0] cmd_failed;
    logic [prs_pkg::SUPPLY_W-1:0] chk_mask;
    logic                         chk_fail;
    logic                         dis, bok;
    logic [prs_pkg::GROUP_W-1:0]  grp;
    logic [prs_pkg::EVENT_W-1:0]  ev;

    assign good = i_tick.good_bits & USED_RAILS;

    // command applied to the flags first
    always_comb begin
        cmd_down   = r_down_req;
        cmd_temp   = r_temp_alarm;
        cmd_rail   = r_rail_alarm;
        cmd_failed = r_failed;
        unique case (i_tick.kind)
            prs_pkg::CMD_POWER_OFF: cmd_down = 1'b1;
            prs_pkg::CMD_TEMP_SET:  cmd_temp = 1'b1;
            prs_pkg::CMD_TEMP_CLR:  cmd_temp = 1'b0;
            prs_pkg::CMD_POWER_ON:  cmd_down = 1'b0;
            prs_pkg::CMD_ALARM_CLR: begin
                cmd_rail   = 1'b0;
                cmd_failed = '0;
            end
            default: ;
        endcase
    end

    // supplies the current stage requires good
    always_comb begin
        unique case (r_state)
            prs_pkg::ST_ON:    chk_mask = i_cfg.general_mask;
            prs_pkg::ST_CLOCK: chk_mask = i_cfg.clock_mask;
            prs_pkg::ST_KU:    chk_mask = i_cfg.ku_mask;
            prs_pkg::ST_ZU:    chk_mask = i_cfg.zu_mask;
            prs_pkg::ST_VU:    chk_mask = i_cfg.vu_mask;
            prs_pkg::ST_FF:    chk_mask = i_cfg.ff_mask;
            default:           chk_mask = '0;
        endcase
    end

    assign chk_fail = ((good & chk_mask) != chk_mask) && !i_cfg.ignore_fail;

    // state decision
    always_comb begin
        n_state      = r_state;
        n_down_req   = cmd_down;
        n_temp_alarm = cmd_temp;
        n_rail_alarm = cmd_rail;
        n_failed     = cmd_failed;
        dis          = 1'b0;
        grp          = prs_pkg::GRP_NONE;
        bok          = 1'b0;
        ev           = prs_pkg::EV_NONE;
        unique case (r_state)
            prs_pkg::ST_INIT: n_state = prs_pkg::ST_OFF;
            prs_pkg::ST_ON: begin
                priority if (chk_fail) begin
                    n_failed     = ~good & chk_mask;
                    n_rail_alarm = 1'b1;
                    dis          = 1'b1;
                    ev           = prs_pkg::EV_SUPPLY;
                    n_state      = prs_pkg::ST_FAIL;
                end else if (cmd_temp) begin
                    dis     = 1'b1;
                    ev      = prs_pkg::EV_TEMP_OFF;
                    n_state = prs_pkg::ST_FAIL;
                end else if (!i_tick.blade_enable || cmd_down) begin
                    n_state = prs_pkg::ST_DOWN;
                end else begin
                    n_state = prs_pkg::ST_ON;
                end
            end
            prs_pkg::ST_DOWN: begin
                dis     = 1'b1;
                ev      = prs_pkg::EV_POWER_OFF;
                n_state = prs_pkg::ST_OFF;
            end
            prs_pkg::ST_OFF: begin
                if (i_tick.blade_enable && !cmd_down && !cmd_temp && !cmd_rail) begin
                    grp     = prs_pkg::GRP_1;
                    ev      = prs_pkg::EV_POWER_ON;
                    n_state = prs_pkg::ST_CLOCK;
                end
            end
            prs_pkg::ST_CLOCK, prs_pkg::ST_KU, prs_pkg::ST_ZU,
            prs_pkg::ST_VU, prs_pkg::ST_FF: begin
                if (chk_fail) begin
                    n_failed     = ~good & chk_mask;
                    n_rail_alarm = 1'b1;
                    dis          = 1'b1;
                    ev           = prs_pkg::EV_SUPPLY;
                    n_state      = prs_pkg::ST_FAIL;
                end else begin
                    unique case (r_state)
                        prs_pkg::ST_CLOCK: begin
                            grp     = prs_pkg::GRP_2;
                            n_state = i_cfg.alternate_path ? prs_pkg::ST_VU
                                                           : prs_pkg::ST_KU;
                        end
                        prs_pkg::ST_KU: begin
                            grp     = prs_pkg::GRP_3;
                            n_state = prs_pkg::ST_ZU;
                        end
                        prs_pkg::ST_FF: begin
                            bok     = 1'b1;
                            n_state = prs_pkg::ST_ON;
                        end
                        default: begin
                            // zu and vu both open group four
                            grp     = prs_pkg::GRP_4;
                            n_state = prs_pkg::ST_FF;
                        end
                    endcase
                end
            end
            prs_pkg::ST_FAIL: begin
                if (!cmd_rail && !cmd_temp) begin
                    ev      = prs_pkg::EV_CLEARED;
                    n_state = prs_pkg::ST_OFF;
                end
            end
            default: n_state = prs_pkg::ST_INIT;
        endcase
    end

    // state update once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= prs_pkg::ST_INIT;
            r_down_req   <= 1'b0;
            r_temp_alarm <= 1'b0;
            r_rail_alarm <= 1'b0;
            r_failed     <= '0;
        end else if (i_adv) begin
            r_state      <= n_state;
            r_down_req   <= n_down_req;
            r_temp_alarm <= n_temp_alarm;
            r_rail_alarm <= n_rail_alarm;
            r_failed     <= n_failed;
        end
    end

    always_comb begin
        o_seq.old_state          = r_state;
        o_seq.new_state          = n_state;
        o_seq.disable_all        = dis;
        o_seq.enable_group       = grp;
        o_seq.blade_ok           = bok;
        o_seq.event_code         = ev;
        o_seq.failed_out         = n_failed;
        o_seq.supply_alarm_out   = n_rail_alarm;
        o_seq.external_alarm_out = n_temp_alarm;
    end

endmodule

`default_nettype wire

@@ rtl/core/prs_status_enc.sv @@
// Per-supply status code encoder, one 3-bit lane per supply.
`default_nettype none

module prs_status_enc #(
    parameter int SUPPLY_COUNT = prs_pkg::SUPPLY_COUNT_D
) (
    input  wire logic [prs_pkg::SUPPLY_W-1:0]  i_after,
    input  wire logic [prs_pkg::SUPPLY_W-1:0]  i_general_mask,
    input  wire logic [prs_pkg::SUPPLY_W-1:0]  i_failed,
    input  wire logic [prs_pkg::STATE_W-1:0]   i_old_state,
    output logic      [prs_pkg::STATUS_W-1:0]  o_status
);

    logic off_like, on_like;

    assign off_like = (i_old_state == prs_pkg::ST_OFF) || (i_old_state == prs_pkg::ST_INIT);
    assign on_like  = (i_old_state == prs_pkg::ST_ON)  || (i_old_state == prs_pkg::ST_FAIL);

    // lanes above the supply count stay zero
    always_comb begin
        o_status = '0;
        for (int i = 0; i < prs_pkg::SUPPLY_W; i++) begin
            if (i < SUPPLY_COUNT) begin
                priority if (i_after[i])
                    o_status[i*prs_pkg::CODE_W +: prs_pkg::CODE_W] = prs_pkg::SS_ON;
                else if (!i_general_mask[i])
                    o_status[i*prs_pkg::CODE_W +: prs_pkg::CODE_W] = prs_pkg::SS_DISABLED;
                else if (off_like)
                    o_status[i*prs_pkg::CODE_W +: prs_pkg::CODE_W] = prs_pkg::SS_OFF;
                else if (on_like)
                    o_status[i*prs_pkg::CODE_W +: prs_pkg::CODE_W] =
                        i_failed[i] ? prs_pkg::SS_FAILED : prs_pkg::SS_OFF;
                else
                    o_status[i*prs_pkg::CODE_W +: prs_pkg::CODE_W] = prs_pkg::SS_UNCHANGED;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/power_rail_sequencer.sv @@
// A tick is accepted into the tick register, passes to the result register when the
// output is not stalled, and is taken from the output from there.
// Throughput: one tick per cycle while the output is not stalled; the sequencer state
// closes its loop between the tick register and the result register.
// Input ready follows the result register: it drops only while a result is stalled
// and the tick register is full.
// Reset (synchronous, active low) puts the sequencer in init, clears flags and
// failed mask, loads register defaults and empties both stages.
`default_nettype none

module power_rail_sequencer #(
    parameter int SUPPLY_COUNT = prs_pkg::SUPPLY_COUNT_D
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [prs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [prs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    prs_tick_if.sink                             i_tick,
    prs_result_if.source                         o_result
);

    prs_pkg::t_cfg     cfg;
    prs_pkg::t_seq_out seq;
    prs_pkg::t_tick    r_in;
    prs_pkg::t_result  r_out;
    logic              r_in_valid, r_out_valid;
    logic              adv, in_take;
    logic [prs_pkg::STATUS_W-1:0] status;

    // pipeline control
    assign adv     = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_take = i_tick.valid && i_tick.ready;
    assign i_tick.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_take || (r_in_valid && !adv);
            r_out_valid <= adv || (r_out_valid && !o_result.ready);
        end
    end

    // tick register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.kind            <= i_tick.kind;
            r_in.blade_enable    <= i_tick.blade_enable;
            r_in.good_bits       <= i_tick.good_bits;
            r_in.good_bits_after <= i_tick.good_bits_after;
        end
    end

    prs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    prs_seq_core #(.SUPPLY_COUNT(SUPPLY_COUNT)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (cfg),
        .i_tick  (r_in),
        .o_seq   (seq)
    );

    prs_status_enc #(.SUPPLY_COUNT(SUPPLY_COUNT)) u_status (
        .i_after        (r_in.good_bits_after),
        .i_general_mask (cfg.general_mask),
        .i_failed       (seq.failed_out),
        .i_old_state    (seq.old_state),
        .o_status       (status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.new_state          <= seq.new_state;
            r_out.disable_all        <= seq.disable_all;
            r_out.enable_group       <= seq.enable_group;
            r_out.blade_ok           <= seq.blade_ok;
            r_out.event_code         <= seq.event_code;
            r_out.failed_out         <= seq.failed_out;
            r_out.supply_alarm_out   <= seq.supply_alarm_out;
            r_out.external_alarm_out <= seq.external_alarm_out;
            r_out.status_vector      <= status;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.new_state          = r_out.new_state;
    assign o_result.disable_all        = r_out.disable_all;
    assign o_result.enable_group       = r_out.enable_group;
    assign o_result.blade_ok           = r_out.blade_ok;
    assign o_result.event_code         = r_out.event_code;
    assign o_result.failed_out         = r_out.failed_out;
    assign o_result.supply_alarm_out   = r_out.supply_alarm_out;
    assign o_result.external_alarm_out = r_out.external_alarm_out;
    assign o_result.status_vector      = r_out.status_vector;

endmodule

`default_nettype wire

@@ rtl/core/prs_checker.sv @@
// Port-level checker for the power rail sequencer, bound to the top level.
`default_nettype none

module prs_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_res_valid,
    input wire logic                           i_res_ready,
    input wire logic [prs_pkg::STATE_W-1:0]    i_new_state,
    input wire logic                           i_disable_all,
    input wire logic                           i_blade_ok,
    input wire logic [prs_pkg::EVENT_W-1:0]    i_event_code,
    input wire logic                           i_supply_alarm
);

    // a stalled result keeps its valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result valid dropped while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_res_valid)
        else $error("result valid right after reset");

    // blade-ok only on reaching on, never with a shutdown
    a_blade_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_blade_ok |-> i_new_state == prs_pkg::ST_ON && !i_disable_all)
        else $error("blade ok without reaching on");

    // a supply failure shuts down, raises the alarm and lands in fail
    a_supply_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_event_code == prs_pkg::EV_SUPPLY |->
            i_disable_all && i_supply_alarm && i_new_state == prs_pkg::ST_FAIL)
        else $error("supply failure result inconsistent");

    // any shutdown strobe goes to fail or off
    a_disable_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_disable_all |->
            i_new_state == prs_pkg::ST_FAIL || i_new_state == prs_pkg::ST_OFF)
        else $error("disable strobe with unexpected next state");

endmodule

bind power_rail_sequencer prs_checker u_prs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_result.valid),
    .i_res_ready    (o_result.ready),
    .i_new_state    (o_result.new_state),
    .i_disable_all  (o_result.disable_all),
    .i_blade_ok     (o_result.blade_ok),
    .i_event_code   (o_result.event_code),
    .i_supply_alarm (o_result.supply_alarm_out)
);

`default_nettype wire
